@@ src/irfs_pkg.sv @@
// Package for the IR remote frame sender: widths, register map, reset values,
// the configuration and result structs and the frame phase type.
// Used by every other file of the block but irfs_rsp_if; depends on nothing.
package irfs_pkg;

   localparam int unsigned TICK_W     = 8;
   localparam int unsigned ADDR_W     = 2;
   localparam int unsigned CMD_W      = 4;
   localparam int unsigned SEG_W      = 3;
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   typedef logic [2:0] reg_index_type;

   localparam reg_index_type REG_START_ON  = 3'd0;
   localparam reg_index_type REG_START_OFF = 3'd1;
   localparam reg_index_type REG_ONE_ON    = 3'd2;
   localparam reg_index_type REG_ZERO_ON   = 3'd3;
   localparam reg_index_type REG_BIT_OFF   = 3'd4;
   localparam reg_index_type REG_GAP       = 3'd5;
   localparam reg_index_type REG_DEV_ADDR  = 3'd6;

   localparam logic [TICK_W-1:0] RST_START_ON  = 8'd10;
   localparam logic [TICK_W-1:0] RST_START_OFF = 8'd4;
   localparam logic [TICK_W-1:0] RST_ONE_ON    = 8'd11;
   localparam logic [TICK_W-1:0] RST_ZERO_ON   = 8'd4;
   localparam logic [TICK_W-1:0] RST_BIT_OFF   = 8'd4;
   localparam logic [TICK_W-1:0] RST_GAP       = 8'd20;
   localparam logic [ADDR_W-1:0] RST_DEV_ADDR  = 2'd3;

   // Last segment index of the start, address and command phases.
   localparam logic [SEG_W-1:0] LAST_SEG_START = 3'd1;
   localparam logic [SEG_W-1:0] LAST_SEG_ADDR  = 3'd3;
   localparam logic [SEG_W-1:0] LAST_SEG_CMD   = 3'd7;

   typedef struct packed {
      logic [TICK_W-1:0] start_on_ticks;
      logic [TICK_W-1:0] start_off_ticks;
      logic [TICK_W-1:0] one_on_ticks;
      logic [TICK_W-1:0] zero_on_ticks;
      logic [TICK_W-1:0] bit_off_ticks;
      logic [TICK_W-1:0] gap_ticks;
      logic [ADDR_W-1:0] device_address;
   } cfg_type;

   typedef struct packed {
      logic carrier_on;
      logic busy_res;
   } result_type;

   typedef enum logic [3:0] {
      PHASE_START = 4'b0001,
      PHASE_ADDR  = 4'b0010,
      PHASE_CMD   = 4'b0100,
      PHASE_GAP   = 4'b1000
   } phase_type;

endpackage

@@ src/irfs_req_if.sv @@
// Input channel of the IR remote frame sender: valid/ready plus one item.
// Depends on irfs_pkg for the field widths.
interface irfs_req_if;
   logic                        valid;
   logic                        ready;
   logic                        cmd;
   logic [irfs_pkg::CMD_W-1:0]  command_code;

   modport source (output valid, cmd, command_code, input ready);
   modport sink   (input valid, cmd, command_code, output ready);
endinterface

@@ src/irfs_rsp_if.sv @@
// Result channel of the IR remote frame sender: valid/ready plus one result.
// Self-contained; the payload is two single-bit flags.
interface irfs_rsp_if;
   logic valid;
   logic ready;
   logic carrier_on;
   logic busy_res;

   modport source (output valid, carrier_on, busy_res, input ready);
   modport sink   (input valid, carrier_on, busy_res, output ready);
endinterface

@@ src/irfs_csr.sv @@
// APB-style configuration registers of the IR remote frame sender.
// Depends on irfs_pkg for the register map, reset values and cfg_type.
module irfs_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [irfs_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [irfs_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [irfs_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output irfs_pkg::cfg_type                   cfg
);

   irfs_pkg::cfg_type       cfg_ff;
   irfs_pkg::cfg_type       cfg_in;
   irfs_pkg::reg_index_type reg_sel;
   logic                    wr_en;

   assign pready  = 1'b1;
   assign reg_sel = paddr[4:2];
   assign wr_en   = psel & penable & pwrite;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            irfs_pkg::REG_START_ON:  cfg_in.start_on_ticks  = pwdata[7:0];
            irfs_pkg::REG_START_OFF: cfg_in.start_off_ticks = pwdata[7:0];
            irfs_pkg::REG_ONE_ON:    cfg_in.one_on_ticks    = pwdata[7:0];
            irfs_pkg::REG_ZERO_ON:   cfg_in.zero_on_ticks   = pwdata[7:0];
            irfs_pkg::REG_BIT_OFF:   cfg_in.bit_off_ticks   = pwdata[7:0];
            irfs_pkg::REG_GAP:       cfg_in.gap_ticks       = pwdata[7:0];
            irfs_pkg::REG_DEV_ADDR:  cfg_in.device_address  = pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_sel)
         irfs_pkg::REG_START_ON:  prdata[7:0] = cfg_ff.start_on_ticks;
         irfs_pkg::REG_START_OFF: prdata[7:0] = cfg_ff.start_off_ticks;
         irfs_pkg::REG_ONE_ON:    prdata[7:0] = cfg_ff.one_on_ticks;
         irfs_pkg::REG_ZERO_ON:   prdata[7:0] = cfg_ff.zero_on_ticks;
         irfs_pkg::REG_BIT_OFF:   prdata[7:0] = cfg_ff.bit_off_ticks;
         irfs_pkg::REG_GAP:       prdata[7:0] = cfg_ff.gap_ticks;
         irfs_pkg::REG_DEV_ADDR:  prdata[1:0] = cfg_ff.device_address;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_on_ticks  <= irfs_pkg::RST_START_ON;
         cfg_ff.start_off_ticks <= irfs_pkg::RST_START_OFF;
         cfg_ff.one_on_ticks    <= irfs_pkg::RST_ONE_ON;
         cfg_ff.zero_on_ticks   <= irfs_pkg::RST_ZERO_ON;
         cfg_ff.bit_off_ticks   <= irfs_pkg::RST_BIT_OFF;
         cfg_ff.gap_ticks       <= irfs_pkg::RST_GAP;
         cfg_ff.device_address  <= irfs_pkg::RST_DEV_ADDR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ src/irfs_engine.sv @@
// Frame sequencer of the IR remote frame sender: the sending state and the
// one-step update for a tick or a send item. Depends on irfs_pkg.
module irfs_engine (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step_en,
   input  logic                           cmd,
   input  logic [irfs_pkg::CMD_W-1:0]     command_code,
   input  irfs_pkg::cfg_type              cfg,
   output irfs_pkg::result_type           result_next,
   output irfs_pkg::result_type           result_now
);

   logic                              sending_ff,  sending_in;
   irfs_pkg::phase_type               phase_ff,    phase_in;
   logic [irfs_pkg::SEG_W-1:0]        seg_ff,      seg_in;
   logic [irfs_pkg::TICK_W-1:0]       tick_ff,     tick_in;
   logic [irfs_pkg::CMD_W-1:0]        command_ff,  command_in;
   logic                              carrier_ff,  carrier_in;

   logic [irfs_pkg::TICK_W-1:0]       seg_len;
   logic [irfs_pkg::SEG_W-1:0]        last_seg;
   irfs_pkg::phase_type               phase_after;
   logic                              data_bit;

   // Length of the current segment; odd segments are always carrier off.
   always_comb begin
      data_bit    = 1'b0;
      seg_len     = cfg.bit_off_ticks;
      last_seg    = irfs_pkg::LAST_SEG_CMD;
      phase_after = irfs_pkg::PHASE_GAP;
      unique case (phase_ff)
         irfs_pkg::PHASE_START: begin
            seg_len     = seg_ff[0] ? cfg.start_off_ticks : cfg.start_on_ticks;
            last_seg    = irfs_pkg::LAST_SEG_START;
            phase_after = irfs_pkg::PHASE_ADDR;
         end
         irfs_pkg::PHASE_ADDR: begin
            data_bit    = cfg.device_address[~seg_ff[1]];
            last_seg    = irfs_pkg::LAST_SEG_ADDR;
            phase_after = irfs_pkg::PHASE_CMD;
         end
         irfs_pkg::PHASE_CMD: begin
            data_bit    = command_ff[~seg_ff[2:1]];
         end
         default: ;
      endcase
      if (!seg_ff[0] && (phase_ff != irfs_pkg::PHASE_START)) begin
         seg_len = data_bit ? cfg.one_on_ticks : cfg.zero_on_ticks;
      end
   end

   always_comb begin
      sending_in = sending_ff;
      phase_in   = phase_ff;
      seg_in     = seg_ff;
      tick_in    = tick_ff;
      command_in = command_ff;
      carrier_in = carrier_ff;
      if (cmd) begin
         // A send restarts the frame; the carrier holds until the next tick.
         sending_in = 1'b1;
         phase_in   = irfs_pkg::PHASE_START;
         seg_in     = '0;
         tick_in    = '0;
         command_in = command_code;
      end else if (!sending_ff) begin
         carrier_in = 1'b0;
      end else if (phase_ff == irfs_pkg::PHASE_GAP) begin
         if (tick_ff < cfg.gap_ticks) begin
            carrier_in = 1'b0;
            tick_in    = tick_ff + 1'b1;
         end else begin
            sending_in = 1'b0;
            phase_in   = irfs_pkg::PHASE_START;
            seg_in     = '0;
            tick_in    = '0;
         end
      end else if (tick_ff < seg_len) begin
         carrier_in = ~seg_ff[0];
         tick_in    = tick_ff + 1'b1;
      end else begin
         // The tick that ends a segment only moves on and keeps the carrier.
         if (seg_ff < last_seg) begin
            seg_in = seg_ff + 1'b1;
         end else begin
            seg_in   = '0;
            phase_in = phase_after;
         end
         tick_in = '0;
      end
   end

   assign result_next.carrier_on = carrier_in;
   assign result_next.busy_res   = sending_in;
   assign result_now.carrier_on  = carrier_ff;
   assign result_now.busy_res    = sending_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sending_ff <= 1'b0;
         phase_ff   <= irfs_pkg::PHASE_START;
         seg_ff     <= '0;
         tick_ff    <= '0;
         command_ff <= '0;
         carrier_ff <= 1'b0;
      end else if (step_en) begin
         sending_ff <= sending_in;
         phase_ff   <= phase_in;
         seg_ff     <= seg_in;
         tick_ff    <= tick_in;
         command_ff <= command_in;
         carrier_ff <= carrier_in;
      end
   end

endmodule

@@ src/ir_remote_frame_sender_top.sv @@
// Top level of the IR remote frame sender: input register, frame sequencer,
// result register and configuration registers. Depends on irfs_pkg,
// irfs_req_if, irfs_rsp_if, irfs_csr and irfs_engine.
//
// The block takes one item per clock while the result side keeps up, either a
// timer tick or a request to send a frame, and returns exactly one result per
// item: the carrier enable and the busy flag after that item. An item is
// captured in an input register, goes through the frame sequencer and lands
// in the result register, which offers its result; the sequencer and result
// register stall while a result is held and the result side is not ready.
// The sustained rate is one item per cycle when the result side is ready,
// set by the compare-and-increment update of the sequencer state. The user
// must write the timing registers and the device address through the APB
// port only while no item is in flight; the block does not enforce this.
module ir_remote_frame_sender_top (
   input  logic                                clock,
   input  logic                                reset,
   irfs_req_if.sink                            req,
   irfs_rsp_if.source                          rsp,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [irfs_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [irfs_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [irfs_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   irfs_pkg::cfg_type             cfg;
   irfs_pkg::result_type          result_next;
   irfs_pkg::result_type          result_now;

   logic                          in_valid_ff,  in_valid_in;
   logic                          in_cmd_ff;
   logic [irfs_pkg::CMD_W-1:0]    in_code_ff;
   logic                          out_valid_ff, out_valid_in;
   irfs_pkg::result_type          out_res_ff;

   logic                          step_en;
   logic                          req_take;

   assign step_en   = in_valid_ff & (~out_valid_ff | rsp.ready);
   assign req.ready = ~in_valid_ff | step_en;
   assign req_take  = req.valid & req.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (step_en) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff  <= req.cmd;
         in_code_ff <= req.command_code;
      end
      if (step_en) begin
         out_res_ff <= result_next;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.carrier_on = out_res_ff.carrier_on;
   assign rsp.busy_res   = out_res_ff.busy_res;

   irfs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   irfs_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step_en),
      .cmd          (in_cmd_ff),
      .command_code (in_code_ff),
      .cfg          (cfg),
      .result_next  (result_next),
      .result_now   (result_now)
   );

   // A send item always yields a busy result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      step_en && in_cmd_ff |=> rsp.valid && rsp.busy_res)
      else $error("send item did not produce a busy result");

   // A tick while idle always turns the carrier off.
   assert property (@(posedge clock) disable iff (reset)
      step_en && !in_cmd_ff && !result_now.busy_res |=> rsp.valid && !rsp.carrier_on)
      else $error("idle tick left the carrier on");

   // The input side stalls only when both registers are full and blocked.
   assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> in_valid_ff && out_valid_ff && !rsp.ready)
      else $error("input stalled without a full pipeline");

   // The frame can only end on a tick, never on a send item.
   assert property (@(posedge clock) disable iff (reset)
      $fell(result_now.busy_res) |-> $past(step_en) && !$past(in_cmd_ff))
      else $error("busy dropped on something other than a tick");

endmodule
